>>> design/motor_command_frame_encoder_assert.svh
// assertion macros for the motor command frame encoder checker
// no dependencies
`ifndef MOTOR_COMMAND_FRAME_ENCODER_ASSERT_SVH
`define MOTOR_COMMAND_FRAME_ENCODER_ASSERT_SVH

// checked only out of reset
`define MCFE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mcfe check failed");

// checked in reset too
`define MCFE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mcfe check failed");

`endif

>>> design/mcfe_pkg.sv
// types, constants and datapath functions of the motor command frame encoder
// no dependencies
package mcfe_pkg;

    localparam int N_CH  = 5;
    localparam int N_STG = 18;

    localparam int CH_POS = 0;
    localparam int CH_VEL = 1;
    localparam int CH_KP  = 2;
    localparam int CH_KD  = 3;
    localparam int CH_TOR = 4;

    localparam int KP_LOW  = 0;
    localparam int KP_HIGH = 500;
    localparam int KD_LOW  = 0;
    localparam int KD_HIGH = 5;

    localparam logic signed [31:0] KP_LO_Q = 32'(KP_LOW * 65536);
    localparam logic signed [31:0] KP_HI_Q = 32'(KP_HIGH * 65536);
    localparam logic signed [31:0] KD_LO_Q = 32'(KD_LOW * 65536);
    localparam logic signed [31:0] KD_HI_Q = 32'(KD_HIGH * 65536);

    localparam logic [15:0] FULL16 = 16'hFFFF;
    localparam logic [15:0] FULL12 = 16'h0FFF;
    localparam logic [3:0]  BYTES8 = 4'd8;
    localparam logic [3:0]  BYTES4 = 4'd4;

    typedef enum logic [1:0] {
        MODE_MIT    = 2'd0,
        MODE_POSVEL = 2'd1,
        MODE_VEL    = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_MODE    = 3'd0,
        CFG_CMD_ID  = 3'd1,
        CFG_POS_MIN = 3'd2,
        CFG_POS_MAX = 3'd3,
        CFG_VEL_MIN = 3'd4,
        CFG_VEL_MAX = 3'd5,
        CFG_TOR_MIN = 3'd6,
        CFG_TOR_MAX = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] rem;
        logic [15:0] dvd;
        logic [15:0] quo;
        logic [31:0] span;
        logic        fz;
        logic        ff;
    } t_lane;

    typedef struct packed {
        logic [31:0] mag;
        logic [4:0]  lz;
        logic        sign;
        logic [31:0] word;
    } t_flt;

    typedef struct packed {
        logic                  valid;
        t_lane [N_CH-1:0]      lane;
        t_flt  [1:0]           flt;
    } t_stage;

    // clamp, offset and span
    function automatic t_lane f_front(input logic signed [31:0] x,
                                      input logic signed [31:0] lo,
                                      input logic signed [31:0] hi);
        t_lane l;
        logic signed [32:0] xs, los, his, xc, dd, sp;
        logic lt, gt;
        xs  = {x[31], x};
        los = {lo[31], lo};
        his = {hi[31], hi};
        lt  = xs < los;
        gt  = xs > his;
        xc  = lt ? los : (gt ? his : xs);
        dd  = xc - los;
        sp  = his - los;
        l.rem  = dd[31:0];
        l.dvd  = '0;
        l.quo  = '0;
        l.span = sp[31:0];
        l.fz   = (sp == 33'sd0) || (sp[32] && lt);
        l.ff   = sp[32] && !lt;
        return l;
    endfunction

    // dividend = offset * (2^bits - 1)
    function automatic t_lane f_init(input t_lane li, input logic is16);
        t_lane l;
        logic [47:0] dx, dv;
        l  = li;
        dx = {16'b0, li.rem};
        dv = is16 ? ({li.rem, 16'b0} - dx) : ({4'b0, li.rem, 12'b0} - dx);
        l.rem = dv[47:16];
        l.dvd = dv[15:0];
        return l;
    endfunction

    // one restoring quotient bit
    function automatic t_lane f_div_step(input t_lane li);
        t_lane l;
        logic [32:0] t, df;
        l  = li;
        t  = {li.rem, li.dvd[15]};
        df = t - {1'b0, li.span};
        if (t >= {1'b0, li.span}) begin
            l.rem = df[31:0];
            l.quo = {li.quo[14:0], 1'b1};
        end else begin
            l.rem = t[31:0];
            l.quo = {li.quo[14:0], 1'b0};
        end
        l.dvd = {li.dvd[14:0], 1'b0};
        return l;
    endfunction

    function automatic t_flt f_abs(input logic signed [31:0] x);
        t_flt f;
        f.sign = x[31];
        f.mag  = x[31] ? 32'(-x) : 32'(x);
        f.lz   = '0;
        f.word = '0;
        return f;
    endfunction

    function automatic t_flt f_norm_a(input t_flt fi);
        t_flt f;
        f = fi;
        if (f.mag[31:16] == 16'b0) begin
            f.mag = {f.mag[15:0], 16'b0};
            f.lz  = f.lz + 5'd16;
        end
        if (f.mag[31:24] == 8'b0) begin
            f.mag = {f.mag[23:0], 8'b0};
            f.lz  = f.lz + 5'd8;
        end
        return f;
    endfunction

    function automatic t_flt f_norm_b(input t_flt fi);
        t_flt f;
        f = fi;
        if (f.mag[31:28] == 4'b0) begin
            f.mag = {f.mag[27:0], 4'b0};
            f.lz  = f.lz + 5'd4;
        end
        if (f.mag[31:30] == 2'b0) begin
            f.mag = {f.mag[29:0], 2'b0};
            f.lz  = f.lz + 5'd2;
        end
        if (!f.mag[31]) begin
            f.mag = {f.mag[30:0], 1'b0};
            f.lz  = f.lz + 5'd1;
        end
        return f;
    endfunction

    // round to nearest even and assemble the single
    function automatic t_flt f_round(input t_flt fi);
        t_flt f;
        logic        rup;
        logic [24:0] mant;
        logic [7:0]  e;
        f    = fi;
        rup  = fi.mag[7] && ((|fi.mag[6:0]) || fi.mag[8]);
        mant = {1'b0, fi.mag[31:8]} + {24'b0, rup};
        e    = 8'd142 - {3'b0, fi.lz};
        if (fi.mag == 32'b0) begin
            f.word = '0;
        end else begin
            f.word = {fi.sign, 31'b0}
                   | (({1'b0, e, 23'b0} + {7'b0, mant}) - 32'h0080_0000);
        end
        return f;
    endfunction

    function automatic logic [15:0] f_code(input t_lane l, input logic [15:0] full);
        if (l.fz) begin
            return '0;
        end else if (l.ff) begin
            return full;
        end
        return l.quo & full;
    endfunction

endpackage

>>> design/motor_command_frame_encoder.sv
// Motor command to CAN frame encoder: takes one command word per cycle while the
// output is not stalled and registers its frame through the 16-step restoring
// divider chain that quantizes the MIT values (two front stages, sixteen
// divide stages, one output register). Mode 3 words pass through and give no
// frame. Configuration is read live, so write it only while the pipe is empty.
// depends on mcfe_pkg
module motor_command_frame_encoder
    import mcfe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // target_pos, target_vel, stiffness, damping, feedforward_torque
    input  logic [159:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // frame_id, frame_bytes, payload, zero pad
    output logic [79:0]  o_m_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);

    t_mode              r_mode;
    logic [10:0]        r_cmd_id;
    logic signed [31:0] r_pos_min, r_pos_max, r_vel_min, r_vel_max, r_tor_min, r_tor_max;

    t_stage             r_st [N_STG];
    t_stage             n_st [N_STG];
    logic               r_out_vld;
    logic [79:0]        r_out_data;
    logic [79:0]        n_out_data;
    logic               en;

    logic [15:0] pc, vc, kpc, kdc, tc;
    logic [63:0] mit_payload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_MIT;
            r_cmd_id  <= '0;
            r_pos_min <= '0;
            r_pos_max <= '0;
            r_vel_min <= '0;
            r_vel_max <= '0;
            r_tor_min <= '0;
            r_tor_max <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:    r_mode    <= t_mode'(i_cfg_data[1:0]);
                CFG_CMD_ID:  r_cmd_id  <= i_cfg_data[10:0];
                CFG_POS_MIN: r_pos_min <= i_cfg_data;
                CFG_POS_MAX: r_pos_max <= i_cfg_data;
                CFG_VEL_MIN: r_vel_min <= i_cfg_data;
                CFG_VEL_MAX: r_vel_max <= i_cfg_data;
                CFG_TOR_MIN: r_tor_min <= i_cfg_data;
                CFG_TOR_MAX: r_tor_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    always_comb begin
        n_st[0].valid        = i_s_tvalid;
        n_st[0].lane[CH_POS] = f_front(i_s_tdata[31:0],    r_pos_min, r_pos_max);
        n_st[0].lane[CH_VEL] = f_front(i_s_tdata[63:32],   r_vel_min, r_vel_max);
        n_st[0].lane[CH_KP]  = f_front(i_s_tdata[95:64],   KP_LO_Q,   KP_HI_Q);
        n_st[0].lane[CH_KD]  = f_front(i_s_tdata[127:96],  KD_LO_Q,   KD_HI_Q);
        n_st[0].lane[CH_TOR] = f_front(i_s_tdata[159:128], r_tor_min, r_tor_max);
        n_st[0].flt[0]       = f_abs(i_s_tdata[31:0]);
        n_st[0].flt[1]       = f_abs(i_s_tdata[63:32]);

        n_st[1] = r_st[0];
        for (int c = 0; c < N_CH; c++) begin
            n_st[1].lane[c] = f_init(r_st[0].lane[c], c == CH_POS);
        end
        for (int f = 0; f < 2; f++) begin
            n_st[1].flt[f] = f_norm_a(r_st[0].flt[f]);
        end

        for (int s = 2; s < N_STG; s++) begin
            n_st[s] = r_st[s-1];
            for (int c = 0; c < N_CH; c++) begin
                n_st[s].lane[c] = f_div_step(r_st[s-1].lane[c]);
            end
            for (int f = 0; f < 2; f++) begin
                if (s == 2) begin
                    n_st[s].flt[f] = f_norm_b(r_st[s-1].flt[f]);
                end else if (s == 3) begin
                    n_st[s].flt[f] = f_round(r_st[s-1].flt[f]);
                end
            end
        end
    end

    assign pc  = f_code(r_st[N_STG-1].lane[CH_POS], FULL16);
    assign vc  = f_code(r_st[N_STG-1].lane[CH_VEL], FULL12);
    assign kpc = f_code(r_st[N_STG-1].lane[CH_KP],  FULL12);
    assign kdc = f_code(r_st[N_STG-1].lane[CH_KD],  FULL12);
    assign tc  = f_code(r_st[N_STG-1].lane[CH_TOR], FULL12);

    assign mit_payload = {tc[7:0], kdc[3:0], tc[11:8], kdc[11:4], kpc[7:0],
                          vc[3:0], kpc[11:8], vc[11:4], pc[7:0], pc[15:8]};

    always_comb begin
        unique case (r_mode)
            MODE_MIT:    n_out_data = {1'b0, mit_payload, BYTES8, r_cmd_id};
            MODE_POSVEL: n_out_data = {1'b0, r_st[N_STG-1].flt[1].word,
                                       r_st[N_STG-1].flt[0].word, BYTES8, r_cmd_id};
            MODE_VEL:    n_out_data = {1'b0, 32'b0, r_st[N_STG-1].flt[1].word,
                                       BYTES4, r_cmd_id};
            default:     n_out_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N_STG; s++) begin
                r_st[s].valid <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (en) begin
            for (int s = 0; s < N_STG; s++) begin
                r_st[s].valid <= n_st[s].valid;
            end
            r_out_vld <= r_st[N_STG-1].valid && (r_mode != MODE_NONE);
        end
        if (en) begin
            for (int s = 0; s < N_STG; s++) begin
                r_st[s].lane <= n_st[s].lane;
                r_st[s].flt  <= n_st[s].flt;
            end
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

>>> design/mcfe_checker.sv
// port-level checks of the motor command frame encoder, bound to the top level
// depends on motor_command_frame_encoder_assert.svh
`include "motor_command_frame_encoder_assert.svh"

module mcfe_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [79:0]  o_m_tdata
);

    `MCFE_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_tvalid)
    `MCFE_ASSERT(a_hold_stalled, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid)
    `MCFE_ASSERT(a_ready_when_free, i_clk, i_rst_n, !o_m_tvalid |-> o_s_tready)
    `MCFE_ASSERT(a_byte_count, i_clk, i_rst_n,
        o_m_tvalid |-> (o_m_tdata[14:11] == 4'd8 || o_m_tdata[14:11] == 4'd4))

endmodule

bind motor_command_frame_encoder mcfe_checker u_mcfe_checker (.*);

>>> tb/tb.sv
// testbench for the motor command frame encoder: directed and random commands in all modes
// predicts each CAN frame in-line and checks the output words; depends on mcfe_pkg
module tb;
    import mcfe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [159:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [79:0]  o_m_tdata;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [31:0]  i_cfg_data;

    typedef struct packed {
        logic [63:0] payload;
        logic [3:0]  nbytes;
        logic [10:0] id;
    } t_frame;

    t_frame      frames_due[$];
    int          mismatches;
    int          n_frames;
    longint      cycles;
    t_mode       cur_mode;
    logic [10:0] cur_id;
    logic signed [31:0] lim_lo[3];
    logic signed [31:0] lim_hi[3];

    motor_command_frame_encoder uut (.*);

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("motor_command_frame_encoder verification failed");
            $finish;
        end
    end

    function automatic logic [15:0] quant(logic signed [31:0] x, logic signed [31:0] lo,
                                          logic signed [31:0] hi, int bits);
        longint full, xs, los, his, span;
        full = (64'd1 << bits) - 1;
        xs = x; los = lo; his = hi;
        span = his - los;
        if (xs < los) xs = los;
        else if (xs > his) xs = his;
        if (span == 0) return '0;
        if (span < 0) return (xs == los) ? 16'd0 : 16'(full);
        return 16'(((xs - los) * full) / span);
    endfunction

    function automatic logic [31:0] to_single(logic signed [31:0] v);
        logic [31:0] mag, mant, rem, half;
        int p, sh;
        if (v == 0) return '0;
        mag = v[31] ? 32'(-v) : 32'(v);
        p = 0;
        for (int k = 0; k < 32; k++) if (mag[k]) p = k;
        if (p <= 23) begin
            mant = mag << (23 - p);
        end else begin
            sh = p - 23;
            rem = mag & ((32'd1 << sh) - 1);
            half = 32'd1 << (sh - 1);
            mant = mag >> sh;
            if (rem > half || (rem == half && mant[0])) mant++;
        end
        return {v[31], 31'b0} | ((32'(p - 16 + 127) << 23) + mant - 32'h0080_0000);
    endfunction

    function automatic void predict_frame(logic [159:0] d);
        logic signed [31:0] f[5];
        logic [15:0] pc, vc, kc, dc, tc;
        t_frame fr;
        for (int k = 0; k < 5; k++) f[k] = d[32*k +: 32];
        fr.id = cur_id;
        case (cur_mode)
            MODE_MIT: begin
                pc = quant(f[CH_POS], lim_lo[0], lim_hi[0], 16);
                vc = quant(f[CH_VEL], lim_lo[1], lim_hi[1], 12);
                kc = quant(f[CH_KP], KP_LO_Q, KP_HI_Q, 12);
                dc = quant(f[CH_KD], KD_LO_Q, KD_HI_Q, 12);
                tc = quant(f[CH_TOR], lim_lo[2], lim_hi[2], 12);
                fr.payload = {tc[7:0], dc[3:0], tc[11:8], dc[11:4], kc[7:0],
                              vc[3:0], kc[11:8], vc[11:4], pc[7:0], pc[15:8]};
                fr.nbytes = BYTES8;
            end
            MODE_POSVEL: begin
                fr.payload = {to_single(f[CH_VEL]), to_single(f[CH_POS])};
                fr.nbytes = BYTES8;
            end
            MODE_VEL: begin
                fr.payload = {32'b0, to_single(f[CH_VEL])};
                fr.nbytes = BYTES4;
            end
            default: return;
        endcase
        frames_due.push_back(fr);
    endfunction

    // output side: random stalls, compare each word against the oldest frame
    initial begin
        int gap;
        t_frame got, want;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            i_m_tready = 1'b0;
            repeat (gap) @(negedge i_clk);
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_rst_n));
            got = o_m_tdata[78:0];
            n_frames++;
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected frame %h", got);
            end else begin
                want = frames_due.pop_front();
                if (got.id !== want.id || got.nbytes !== want.nbytes
                        || got.payload !== want.payload) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("frame mismatch: expected id %h n %h p %h, got id %h n %h p %h",
                                 want.id, want.nbytes, want.payload,
                                 got.id, got.nbytes, got.payload);
                end
            end
        end
    end

    task automatic send_command(logic [159:0] d);
        repeat ($urandom_range(0, 3)) @(negedge i_clk);
        i_s_tdata = d;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        predict_frame(d);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic drain_pipe();
        while (frames_due.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_MODE:    cur_mode = t_mode'(val[1:0]);
            CFG_CMD_ID:  cur_id = val[10:0];
            CFG_POS_MIN: lim_lo[0] = val;
            CFG_POS_MAX: lim_hi[0] = val;
            CFG_VEL_MIN: lim_lo[1] = val;
            CFG_VEL_MAX: lim_hi[1] = val;
            CFG_TOR_MIN: lim_lo[2] = val;
            CFG_TOR_MAX: lim_hi[2] = val;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_value(logic signed [31:0] lo, logic signed [31:0] hi);
        longint span;
        span = longint'(hi) - longint'(lo) + 1;
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return lo;
            3: return hi;
            4: return 32'(lo + $signed($urandom_range(0, 3)) - 1);
            5: return $urandom();
            default: return (span > 0) ? 32'(longint'(lo) + longint'($urandom()) % span)
                                       : $urandom();
        endcase
    endfunction

    function automatic logic [159:0] random_command();
        logic [159:0] d;
        d[31:0]    = pick_value(lim_lo[0], lim_hi[0]);
        d[63:32]   = pick_value(lim_lo[1], lim_hi[1]);
        d[95:64]   = pick_value(KP_LO_Q, KP_HI_Q);
        d[127:96]  = pick_value(KD_LO_Q, KD_HI_Q);
        d[159:128] = pick_value(lim_lo[2], lim_hi[2]);
        return d;
    endfunction

    task automatic set_limits(logic [31:0] pl, logic [31:0] ph, logic [31:0] vl,
                              logic [31:0] vh, logic [31:0] tl, logic [31:0] th);
        write_reg(CFG_POS_MIN, pl); write_reg(CFG_POS_MAX, ph);
        write_reg(CFG_VEL_MIN, vl); write_reg(CFG_VEL_MAX, vh);
        write_reg(CFG_TOR_MIN, tl); write_reg(CFG_TOR_MAX, th);
    endtask

    task automatic test_mit_directed();
        drain_pipe();
        write_reg(CFG_MODE, MODE_MIT);
        write_reg(CFG_CMD_ID, 32'h7FF);
        set_limits(32'hFFF3_7000, 32'h000C_9000, 32'hFFE2_0000, 32'h001E_0000,
                   32'hFFF6_0000, 32'h000A_0000);
        send_command({5{32'h8000_0000}});
        send_command({5{32'h7FFF_FFFF}});
        send_command('0);
        send_command({32'h000A_0000, KD_HI_Q, KP_HI_Q, 32'h001E_0000, 32'h000C_9000});
        send_command({32'h0000_8000, 32'h0001_0000, 32'h0064_0000, 32'hFFFF_0000, 32'h1});
        drain_pipe();
        // zero span and inverted ranges
        set_limits(32'h0001_0000, 32'h0001_0000, 32'h0005_0000, 32'hFFFB_0000,
                   32'h7FFF_FFFF, 32'h8000_0000);
        send_command('0);
        send_command({32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0005_0000, 32'h0001_0000});
        send_command({32'h8000_0000, 32'h0002_0000, 32'h1, 32'hFFFB_0000, 32'h0000_FFFF});
        drain_pipe();
        set_limits(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF);
        send_command({5{32'h8000_0000}});
        send_command({5{32'h7FFF_FFFF}});
        send_command({5{32'h5555_AAAA}});
    endtask

    task automatic test_float_directed();
        drain_pipe();
        write_reg(CFG_MODE, MODE_POSVEL);
        write_reg(CFG_CMD_ID, 32'h0);
        send_command({96'b0, 32'h8000_0000, 32'h7FFF_FFFF});
        send_command({96'b0, 32'h0000_0001, 32'hFFFF_FFFF});
        send_command({96'b0, 32'h0100_0080, 32'h0100_0180});
        send_command({96'b0, 32'h0, 32'h0100_0081});
        drain_pipe();
        write_reg(CFG_MODE, MODE_VEL);
        write_reg(CFG_CMD_ID, 32'h301);
        send_command({96'b0, 32'hFEFF_FF80, 32'h1234});
        send_command({96'b0, 32'h0, 32'h0});
        drain_pipe();
        write_reg(CFG_MODE, MODE_NONE);
        send_command({5{32'hDEAD_BEEF}});
        send_command('0);
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 26; ph++) begin
            drain_pipe();
            write_reg(CFG_MODE, ($urandom_range(0, 19) == 0) ? MODE_NONE
                                                               : t_mode'($urandom_range(0, 2)));
            write_reg(CFG_CMD_ID, $urandom_range(0, 2047));
            if ($urandom_range(0, 3) == 0)
                set_limits($urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom());
            else
                set_limits(-$urandom_range(1, 1 << 24), $urandom_range(0, 1 << 24),
                           -$urandom_range(0, 1 << 22), $urandom_range(1, 1 << 22),
                           -$urandom_range(1, 1 << 20), $urandom_range(1, 1 << 20));
            for (int k = 0; k < 75; k++) begin
                if (k == 40 && ph == 3) drain_pipe();
                send_command(random_command());
            end
        end
    endtask

    initial begin
        cycles = 0;
        mismatches = 0;
        n_frames = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MODE;
        i_cfg_data = '0;
        cur_mode = MODE_MIT;
        cur_id = '0;
        for (int k = 0; k < 3; k++) begin
            lim_lo[k] = '0;
            lim_hi[k] = '0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_mit_directed();
        test_float_directed();
        test_random();
        drain_pipe();
        if (mismatches == 0 && frames_due.size() == 0)
            $display("motor_command_frame_encoder verification clean");
        else
            $display("motor_command_frame_encoder verification failed");
        $finish;
    end
endmodule
